// ===== hdl/pidsc_pkg.sv =====
// Package for the PID speed correction core: widths, register indexes,
// fixed limits and the 48-bit saturation helper.
// No dependencies.
package pidsc_pkg;

   // Field and datapath widths
   localparam int GAIN_W     = 32;   // signed gains
   localparam int STEP_W     = 31;   // unsigned period, reciprocal, threshold
   localparam int IN_W       = 32;   // measured and target values
   localparam int ERR_W      = 33;   // measured minus target
   localparam int DIFF_W     = 34;   // error minus last error
   localparam int OPA_W      = 33;   // signed serial operand before magnitude
   localparam int OPB_W      = 49;   // signed parallel operand before magnitude
   localparam int MAGA_W     = 32;   // serial operand magnitude
   localparam int MAGB_W     = 48;   // parallel operand magnitude
   localparam int PROD_W     = MAGA_W + MAGB_W;
   localparam int STATE_W    = 48;   // integral, derivative, saturated sum
   localparam int SUM_W      = 50;   // three-term sum before saturation
   localparam int DIGIT_W    = 4;    // multiplier digit per cycle
   localparam int DIGITS     = MAGA_W / DIGIT_W;
   localparam int CNT_W      = $clog2(DIGITS);
   localparam int OUT_CORR_W = 6;
   localparam int CORR_LIMIT = 30;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_OVERALL_GAIN    = 3'd0;
   localparam csr_idx_type CSR_PROP_GAIN       = 3'd1;
   localparam csr_idx_type CSR_INTEG_GAIN      = 3'd2;
   localparam csr_idx_type CSR_DERIV_GAIN      = 3'd3;
   localparam csr_idx_type CSR_STEP_PERIOD     = 3'd4;
   localparam csr_idx_type CSR_INV_STEP_PERIOD = 3'd5;
   localparam csr_idx_type CSR_ERROR_THRESHOLD = 3'd6;

   // 1.0 in unsigned Q15.16 at the period width (the core resets its periods to PERIOD_ONE)
   localparam logic [STEP_W-1:0] STEP_ONE = 31'd65536;

   // 48-bit signed limits, held at sum width
   localparam logic signed [SUM_W-1:0] SAT_HI = {3'b000, {47{1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = {3'b111, {47{1'b0}}};

   // Clamp a sum to the 48-bit signed range
   function automatic logic signed [STATE_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
      logic signed [STATE_W-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[STATE_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[STATE_W-1:0];
      end else begin
         r = v[STATE_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/pid_speed_correction_core.sv =====
// PID speed correction core: conditional integration, derivative, gain
// product, clamp and fractional carry. One shared digit-serial multiplier.
// Depends on pidsc_pkg.
//
// Sequence: each product runs load, 8 digit steps, round and apply on the shared
//   4-bit-digit multiplier, and 4 to 6 products run per word.
// Flow: one word in flight; the next word is taken while the previous
//   result waits in the output register.
// Reset: synchronous, active high; gains clear, periods load 1.0, integral,
//   last error, start flag and carry clear. No clearing pass.
module pid_speed_correction_core #(
   parameter int POSITION_BITS = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // input words
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [pidsc_pkg::IN_W-1:0]           req_measured_value,
   input  logic signed [pidsc_pkg::IN_W-1:0]           req_target_value,
   input  logic        [POSITION_BITS-1:0]             req_actuator_position,
   // result words
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [pidsc_pkg::OUT_CORR_W-1:0]     rsp_step_correction,
   output logic        [POSITION_BITS-1:0]             rsp_next_position,
   // configuration writes
   input  logic                                        csr_write_en,
   input  logic        [pidsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic        [pidsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pidsc_pkg::*;

   localparam int FB      = FRACTION_BITS;
   localparam int PB      = POSITION_BITS;
   localparam int CORR_W  = FB + 6;     // clamped result plus carry
   localparam int CARRY_W = FB + 1;
   localparam int NP_W    = PB + 2;
   localparam logic signed [STATE_W-1:0] CORR_LIM     = 48'(CORR_LIMIT * (1 << FB));
   localparam logic signed [STATE_W-1:0] CORR_LIM_NEG = -CORR_LIM;
   localparam logic signed [OUT_CORR_W-1:0] OUT_MAX   = 6'sd30;
   localparam logic signed [OUT_CORR_W-1:0] OUT_MIN   = -6'sd30;
   // 1.0 at the configured fraction width
   localparam logic [STEP_W-1:0] PERIOD_ONE = STEP_W'(1 << FB);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_LOAD, ST_MUL, ST_USE, ST_APPLY, ST_CORR, ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      OP_INTEG, OP_DERIV, OP_PROP, OP_INTG, OP_DTERM, OP_OVER
   } op_type;

   // control
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic started_ff, started_in;
   logic first_ff, first_in;

   // configuration
   logic signed [GAIN_W-1:0] overall_gain_ff, overall_gain_in;
   logic signed [GAIN_W-1:0] prop_gain_ff, prop_gain_in;
   logic signed [GAIN_W-1:0] integ_gain_ff, integ_gain_in;
   logic signed [GAIN_W-1:0] deriv_gain_ff, deriv_gain_in;
   logic [STEP_W-1:0] step_period_ff, step_period_in;
   logic [STEP_W-1:0] inv_step_period_ff, inv_step_period_in;
   logic [STEP_W-1:0] error_threshold_ff, error_threshold_in;

   // loop state
   logic signed [ERR_W-1:0]   last_err_ff, last_err_in;
   logic signed [STATE_W-1:0] integ_ff, integ_in;
   logic signed [CARRY_W-1:0] carry_ff, carry_in;

   // per-word datapath
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic        [ERR_W-1:0]   err_mag_ff, err_mag_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic        [PB-1:0]      pos_ff, pos_in;
   logic signed [STATE_W-1:0] deriv_ff, deriv_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic        [MAGA_W-1:0]  a_ff, a_in;
   logic        [MAGB_W-1:0]  b_ff, b_in;
   logic                      neg_ff, neg_in;
   logic        [MAGB_W-1:0]  acc_ff, acc_in;
   logic        [MAGA_W-1:0]  low_ff, low_in;
   logic signed [STATE_W-1:0] prod_ff, prod_in;
   logic signed [CORR_W-1:0]  res_ff, res_in;
   logic signed [CORR_W-1:0]  corr_ff, corr_in;

   // output register
   logic signed [OUT_CORR_W-1:0] rsp_corr_ff, rsp_corr_in;
   logic        [PB-1:0]         rsp_pos_ff, rsp_pos_in;

   // operand select, magnitudes
   logic signed [OPA_W-1:0] a_src, a_neg;
   logic signed [OPB_W-1:0] b_src, b_neg;
   logic [MAGA_W-1:0] a_mag;
   logic [MAGB_W-1:0] b_mag;

   // digit step and product rounding
   logic [MAGB_W+DIGIT_W-1:0] acc_sum;
   logic [PROD_W-1:0]         full_prod;
   logic                      prod_over;
   logic [STATE_W-2:0]        p_mag;
   logic signed [STATE_W-1:0] p_pos;
   logic signed [SUM_W-1:0]   sum_add;
   logic signed [SUM_W-1:0]   integ_add;
   logic signed [CORR_W-1:0]  res_clamp;
   logic                      band_hit;

   // final correction split
   logic                      corr_neg;
   logic [CORR_W-1:0]         corr_mag;
   logic [4:0]                corr_whole;
   logic [FB-1:0]             corr_frac;
   logic signed [OUT_CORR_W-1:0] corr_int;
   logic signed [CARRY_W-1:0] carry_next;
   logic signed [NP_W-1:0]    np_sum;
   logic [PB-1:0]             np_sat;

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_step_correction = rsp_corr_ff;
   assign rsp_next_position   = rsp_pos_ff;

   // pick multiplier operands for the current term
   always_comb begin
      unique case (op_ff)
         OP_INTEG: begin
            a_src = {2'b00, step_period_ff};
            b_src = OPB_W'(err_ff);
         end
         OP_DERIV: begin
            a_src = {2'b00, inv_step_period_ff};
            b_src = OPB_W'(diff_ff);
         end
         OP_PROP: begin
            a_src = OPA_W'(prop_gain_ff);
            b_src = OPB_W'(err_ff);
         end
         OP_INTG: begin
            a_src = OPA_W'(integ_gain_ff);
            b_src = OPB_W'(integ_ff);
         end
         OP_DTERM: begin
            a_src = OPA_W'(deriv_gain_ff);
            b_src = OPB_W'(deriv_ff);
         end
         OP_OVER: begin
            a_src = OPA_W'(overall_gain_ff);
            b_src = OPB_W'($signed(sum_ff[STATE_W-1:0]));
         end
         default: begin
            a_src = '0;
            b_src = '0;
         end
      endcase
   end

   assign a_neg = -a_src;
   assign b_neg = -b_src;
   assign a_mag = a_src[OPA_W-1] ? a_neg[MAGA_W-1:0] : a_src[MAGA_W-1:0];
   assign b_mag = b_src[OPB_W-1] ? b_neg[MAGB_W-1:0] : b_src[MAGB_W-1:0];

   // one digit of the serial operand against the full parallel operand
   assign acc_sum = {{DIGIT_W{1'b0}}, acc_ff} + (b_ff * a_ff[DIGIT_W-1:0]);

   // drop the fraction and saturate the magnitude; the sign is applied in ST_USE
   assign full_prod = {acc_ff, low_ff};
   assign prod_over = |full_prod[PROD_W-1:FB+STATE_W-1];
   assign p_mag     = prod_over ? {(STATE_W-1){1'b1}} : full_prod[FB+STATE_W-2:FB];
   assign p_pos     = {1'b0, p_mag};

   assign sum_add   = sum_ff + SUM_W'(prod_ff);
   assign integ_add = SUM_W'(integ_ff) + SUM_W'(prod_ff);
   assign band_hit  = (err_mag_ff < {2'b00, error_threshold_ff});

   // clamp the gained result to the correction limit
   always_comb begin
      priority if (prod_ff > CORR_LIM) begin
         res_clamp = CORR_W'(CORR_LIM);
      end else if (prod_ff < CORR_LIM_NEG) begin
         res_clamp = CORR_W'(CORR_LIM_NEG);
      end else begin
         res_clamp = CORR_W'(prod_ff);
      end
   end

   // split the corrected value into whole steps and carried fraction
   assign corr_neg   = corr_ff[CORR_W-1];
   assign corr_mag   = corr_neg ? CORR_W'(-corr_ff) : CORR_W'(corr_ff);
   assign corr_whole = corr_mag[FB+4:FB];
   assign corr_frac  = corr_mag[FB-1:0];
   assign corr_int   = corr_neg ? -$signed({1'b0, corr_whole}) : $signed({1'b0, corr_whole});
   assign carry_next = corr_neg ? -$signed({1'b0, corr_frac}) : $signed({1'b0, corr_frac});
   assign np_sum     = $signed({2'b00, pos_ff}) + NP_W'(corr_int);

   // hold the new position inside its range
   always_comb begin
      priority if (np_sum[NP_W-1]) begin
         np_sat = '0;
      end else if (np_sum[NP_W-2]) begin
         np_sat = '1;
      end else begin
         np_sat = np_sum[PB-1:0];
      end
   end

   // sequencer and register next values
   always_comb begin
      state_in           = state_ff;
      op_in              = op_ff;
      cnt_in             = cnt_ff;
      rsp_valid_in       = rsp_valid_ff;
      started_in         = started_ff;
      first_in           = first_ff;
      overall_gain_in    = overall_gain_ff;
      prop_gain_in       = prop_gain_ff;
      integ_gain_in      = integ_gain_ff;
      deriv_gain_in      = deriv_gain_ff;
      step_period_in     = step_period_ff;
      inv_step_period_in = inv_step_period_ff;
      error_threshold_in = error_threshold_ff;
      last_err_in        = last_err_ff;
      integ_in           = integ_ff;
      carry_in           = carry_ff;
      err_in             = err_ff;
      err_mag_in         = err_mag_ff;
      diff_in            = diff_ff;
      pos_in             = pos_ff;
      deriv_in           = deriv_ff;
      sum_in             = sum_ff;
      a_in               = a_ff;
      b_in               = b_ff;
      neg_in             = neg_ff;
      acc_in             = acc_ff;
      low_in             = low_ff;
      prod_in            = prod_ff;
      res_in             = res_ff;
      corr_in            = corr_ff;
      rsp_corr_in        = rsp_corr_ff;
      rsp_pos_in         = rsp_pos_ff;

      // take register writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_OVERALL_GAIN:    overall_gain_in    = $signed(csr_wdata);
            CSR_PROP_GAIN:       prop_gain_in       = $signed(csr_wdata);
            CSR_INTEG_GAIN:      integ_gain_in      = $signed(csr_wdata);
            CSR_DERIV_GAIN:      deriv_gain_in      = $signed(csr_wdata);
            CSR_STEP_PERIOD:     step_period_in     = csr_wdata[STEP_W-1:0];
            CSR_INV_STEP_PERIOD: inv_step_period_in = csr_wdata[STEP_W-1:0];
            CSR_ERROR_THRESHOLD: error_threshold_in = csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end

      // drop the result word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               err_in   = ERR_W'(req_measured_value) - ERR_W'(req_target_value);
               pos_in   = req_actuator_position;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            err_mag_in  = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
            diff_in     = DIFF_W'(err_ff) - DIFF_W'(last_err_ff);
            last_err_in = err_ff;
            first_in    = !started_ff;
            started_in  = 1'b1;
            op_in       = OP_INTEG;
            state_in    = ST_LOAD;
         end
         ST_LOAD: begin
            priority if (op_ff == OP_INTEG && !band_hit) begin
               integ_in = '0;
               op_in    = OP_DERIV;
            end else if (op_ff == OP_DERIV && first_ff) begin
               deriv_in = '0;
               op_in    = OP_PROP;
            end else begin
               a_in     = a_mag;
               b_in     = b_mag;
               neg_in   = a_src[OPA_W-1] ^ b_src[OPB_W-1];
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // advance one digit: low product bits shift into low_ff
            acc_in = acc_sum[MAGB_W+DIGIT_W-1:DIGIT_W];
            low_in = {acc_sum[DIGIT_W-1:0], low_ff[MAGA_W-1:DIGIT_W]};
            a_in   = a_ff >> DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               state_in = ST_USE;
            end
         end
         ST_USE: begin
            prod_in  = neg_ff ? -p_pos : p_pos;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = ST_LOAD;
            unique case (op_ff)
               OP_INTEG: begin
                  integ_in = sat48(integ_add);
                  op_in    = OP_DERIV;
               end
               OP_DERIV: begin
                  deriv_in = prod_ff;
                  op_in    = OP_PROP;
               end
               OP_PROP: begin
                  sum_in = SUM_W'(prod_ff);
                  op_in  = OP_INTG;
               end
               OP_INTG: begin
                  sum_in = sum_add;
                  op_in  = OP_DTERM;
               end
               OP_DTERM: begin
                  sum_in = SUM_W'(sat48(sum_add));
                  op_in  = OP_OVER;
               end
               OP_OVER: begin
                  res_in   = res_clamp;
                  state_in = ST_CORR;
               end
               default: ;
            endcase
         end
         ST_CORR: begin
            corr_in  = res_ff + CORR_W'(carry_ff);
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // write the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_corr_in  = corr_int;
               rsp_pos_in   = np_sat;
               rsp_valid_in = 1'b1;
               carry_in     = carry_next;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         op_ff              <= OP_INTEG;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
         started_ff         <= 1'b0;
         first_ff           <= 1'b0;
         overall_gain_ff    <= '0;
         prop_gain_ff       <= '0;
         integ_gain_ff      <= '0;
         deriv_gain_ff      <= '0;
         step_period_ff     <= PERIOD_ONE;
         inv_step_period_ff <= PERIOD_ONE;
         error_threshold_ff <= '0;
         last_err_ff        <= '0;
         integ_ff           <= '0;
         carry_ff           <= '0;
      end else begin
         state_ff           <= state_in;
         op_ff              <= op_in;
         cnt_ff             <= cnt_in;
         rsp_valid_ff       <= rsp_valid_in;
         started_ff         <= started_in;
         first_ff           <= first_in;
         overall_gain_ff    <= overall_gain_in;
         prop_gain_ff       <= prop_gain_in;
         integ_gain_ff      <= integ_gain_in;
         deriv_gain_ff      <= deriv_gain_in;
         step_period_ff     <= step_period_in;
         inv_step_period_ff <= inv_step_period_in;
         error_threshold_ff <= error_threshold_in;
         last_err_ff        <= last_err_in;
         integ_ff           <= integ_in;
         carry_ff           <= carry_in;
      end
      err_ff      <= err_in;
      err_mag_ff  <= err_mag_in;
      diff_ff     <= diff_in;
      pos_ff      <= pos_in;
      deriv_ff    <= deriv_in;
      sum_ff      <= sum_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      low_ff      <= low_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      corr_ff     <= corr_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   // checks on the sequencer and datapath
   a_corr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_corr_ff <= OUT_MAX) && (rsp_corr_ff >= OUT_MIN))
      else $error("step correction outside limit");

   a_carry_below_one: assert property (@(posedge clock) disable iff (reset)
      !(carry_ff[CARRY_W-1] && (carry_ff[FB-1:0] == '0)))
      else $error("carried fraction reached minus one");

   a_prod_symmetric: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY) |-> (SUM_W'(prod_ff) != SAT_LO))
      else $error("saturated product took the negative extreme");

   a_fin_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ready) |=> (state_ff == ST_FIN))
      else $error("result written over a pending word");

   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("start flag dropped without reset");

endmodule
